FILE: sv/tch_pkg.sv
// ----------------------------------------------------------------------------
// tch_pkg: shared types and constants of the tilt compensated heading block
// Widths of the fixed-point datapath, the arctangent table and the structs
// handed between the pipeline cells.
// ----------------------------------------------------------------------------
`default_nettype none

package tch_pkg;

  // default parameter values
  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int CORDIC_STEPS_DEF = 16;

  // datapath widths
  localparam int RED_W  = 16;   // reduced sample
  localparam int PRD_W  = 32;   // 16 x 16 product
  localparam int S_W    = 33;   // gy*mz - gz*my
  localparam int G2_W   = 32;   // |g|^2
  localparam int MG_W   = 33;   // m.g
  localparam int D_W    = 49;   // gx*mg - mx*g2
  localparam int GFRAC  = 8;
  localparam int RAD_W  = 2 * G2_W - 2 * GFRAC;  // g2 scaled by 2^16, square root operand
  localparam int ROOT_W = RAD_W / 2;
  localparam int REM_W  = ROOT_W + 2;
  localparam int TERM_W = 58;   // sine and cosine terms
  localparam int MAG_W  = TERM_W - 1;
  localparam int NORM_BITS = 29;
  localparam int XY_W   = 33;
  localparam int Z_W    = 27;
  localparam int HQ_W   = 28;
  localparam int ATAN_W = 22;
  localparam int MAX_STEPS = 24;

  localparam logic signed [Z_W-1:0]  Z180 = Z_W'(180 * 65536);
  localparam logic signed [HQ_W-1:0] HQ180 = HQ_W'(180 * 65536);
  localparam logic signed [HQ_W-1:0] HQ360 = HQ_W'(360 * 65536);

  // atan(2^-i) in degrees, Q16
  localparam logic [ATAN_W-1:0] ATAN_Q16 [MAX_STEPS] = '{
    22'd2949120, 22'd1740967, 22'd919879, 22'd466945, 22'd234379, 22'd117304,
    22'd58666, 22'd29335, 22'd14668, 22'd7334, 22'd3667, 22'd1833,
    22'd917, 22'd458, 22'd229, 22'd115, 22'd57, 22'd29,
    22'd14, 22'd7, 22'd4, 22'd2, 22'd1, 22'd0
  };

  // data that rides alongside the square root cells
  typedef struct packed {
    logic                  zero_g;
    logic signed [S_W-1:0] s;
    logic signed [D_W-1:0] d;
  } side_t;

  // square root cell state
  typedef struct packed {
    logic [RAD_W-1:0]  rad;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } sqrt_t;

  // rotation cell state
  typedef struct packed {
    logic                   zero_g;
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
  } cord_t;

  // one result beat
  typedef struct packed {
    logic [8:0] heading_deg;
    logic       no_gravity;
  } res_t;

  // pipeline control between cells
  typedef struct packed {
    logic en;
    logic valid;
  } ctl_t;

endpackage

`default_nettype wire

FILE: sv/tch_in_if.sv
// ----------------------------------------------------------------------------
// tch_in_if: sensor sample channel
// Valid/ready channel carrying one gravity and one magnetic vector.
// ----------------------------------------------------------------------------
`default_nettype none

interface tch_in_if #(
  parameter int SAMPLE_WIDTH = tch_pkg::SAMPLE_WIDTH_DEF
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] grav_x;
  logic signed [SAMPLE_WIDTH-1:0] grav_y;
  logic signed [SAMPLE_WIDTH-1:0] grav_z;
  logic signed [SAMPLE_WIDTH-1:0] mag_x;
  logic signed [SAMPLE_WIDTH-1:0] mag_y;
  logic signed [SAMPLE_WIDTH-1:0] mag_z;

  modport source (output valid, grav_x, grav_y, grav_z, mag_x, mag_y, mag_z, input ready);
  modport sink   (input valid, grav_x, grav_y, grav_z, mag_x, mag_y, mag_z, output ready);
endinterface

`default_nettype wire

FILE: sv/tch_out_if.sv
// ----------------------------------------------------------------------------
// tch_out_if: heading result channel
// Valid/ready channel carrying one heading and the no gravity flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface tch_out_if;
  logic       valid;
  logic       ready;
  logic [8:0] heading_deg;
  logic       no_gravity;

  modport source (output valid, heading_deg, no_gravity, input ready);
  modport sink   (input valid, heading_deg, no_gravity, output ready);
endinterface

`default_nettype wire

FILE: sv/tilt_compensated_heading.sv
// ----------------------------------------------------------------------------
// tilt_compensated_heading: compass heading from gravity and magnetic vectors
//
// Input channel sens: one beat carries grav_x/y/z and mag_x/y/z as signed
// raw counts. Output channel res: one beat per input beat, heading_deg in
// whole degrees 0..359 and no_gravity, set (with heading 0) when the raw
// gravity vector is all zero.
// Throughput is one beat per cycle while the output buffer has room. From
// acceptance to res.valid a beat passes the input register, the products
// and sums, one square root cell per root bit (24), the forming and
// normalising of the sine and cosine terms, one rotation cell per CORDIC
// step, the degree conversion and the output buffer.
// Reset empties the pipeline and the output buffer. When res stalls, the
// two-entry output buffer keeps taking results; once it is full the whole
// pipeline holds and sens.ready drops, resuming as res beats are taken.
// ----------------------------------------------------------------------------
`default_nettype none

module tilt_compensated_heading #(
  parameter int SAMPLE_WIDTH = tch_pkg::SAMPLE_WIDTH_DEF,
  parameter int CORDIC_STEPS = tch_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  tch_in_if.sink    sens,
  tch_out_if.source res
);

  localparam int SQ_N = tch_pkg::ROOT_W;

  logic          en;
  logic          full;

  // sample reduction
  logic signed [tch_pkg::RED_W-1:0] gx_r, gy_r, gz_r, mx_r, my_r, mz_r;

  if (SAMPLE_WIDTH > tch_pkg::RED_W) begin : g_reduce
    assign gx_r = sens.grav_x[SAMPLE_WIDTH-1 -: tch_pkg::RED_W];
    assign gy_r = sens.grav_y[SAMPLE_WIDTH-1 -: tch_pkg::RED_W];
    assign gz_r = sens.grav_z[SAMPLE_WIDTH-1 -: tch_pkg::RED_W];
    assign mx_r = sens.mag_x[SAMPLE_WIDTH-1 -: tch_pkg::RED_W];
    assign my_r = sens.mag_y[SAMPLE_WIDTH-1 -: tch_pkg::RED_W];
    assign mz_r = sens.mag_z[SAMPLE_WIDTH-1 -: tch_pkg::RED_W];
  end else begin : g_extend
    assign gx_r = tch_pkg::RED_W'(sens.grav_x);
    assign gy_r = tch_pkg::RED_W'(sens.grav_y);
    assign gz_r = tch_pkg::RED_W'(sens.grav_z);
    assign mx_r = tch_pkg::RED_W'(sens.mag_x);
    assign my_r = tch_pkg::RED_W'(sens.mag_y);
    assign mz_r = tch_pkg::RED_W'(sens.mag_z);
  end

  assign en         = !full;
  assign sens.ready = en;

  // stage 0: reduced samples
  logic signed [tch_pkg::RED_W-1:0] gx0, gy0, gz0, mx0, my0, mz0;
  logic                             zg0, v0;

  always_ff @(posedge clk) begin
    if (en) begin
      gx0 <= gx_r; gy0 <= gy_r; gz0 <= gz_r;
      mx0 <= mx_r; my0 <= my_r; mz0 <= mz_r;
      zg0 <= (sens.grav_x == '0) && (sens.grav_y == '0) && (sens.grav_z == '0);
    end
  end

  // stage 1: 16 x 16 products
  logic signed [tch_pkg::PRD_W-1:0] p_ymz, p_zmy, p_xx, p_yy, p_zz, p_mxgx, p_mygy, p_mzgz;
  logic signed [tch_pkg::RED_W-1:0] gx1, mx1;
  logic                             zg1, v1;

  always_ff @(posedge clk) begin
    if (en) begin
      p_ymz  <= gy0 * mz0;
      p_zmy  <= gz0 * my0;
      p_xx   <= gx0 * gx0;
      p_yy   <= gy0 * gy0;
      p_zz   <= gz0 * gz0;
      p_mxgx <= mx0 * gx0;
      p_mygy <= my0 * gy0;
      p_mzgz <= mz0 * gz0;
      gx1    <= gx0;
      mx1    <= mx0;
      zg1    <= zg0;
    end
  end

  // stage 2: cross term, gravity norm squared, m.g
  logic signed [tch_pkg::S_W-1:0]  s2;
  logic        [tch_pkg::G2_W-1:0] g2_2;
  logic signed [tch_pkg::MG_W-1:0] mg2;
  logic signed [tch_pkg::RED_W-1:0] gx2, mx2;
  logic                             zg2, v2;

  always_ff @(posedge clk) begin
    if (en) begin
      s2   <= tch_pkg::S_W'(p_ymz) - tch_pkg::S_W'(p_zmy);
      g2_2 <= $unsigned(p_xx) + $unsigned(p_yy) + $unsigned(p_zz);
      mg2  <= tch_pkg::MG_W'(p_mxgx) + tch_pkg::MG_W'(p_mygy) + tch_pkg::MG_W'(p_mzgz);
      gx2  <= gx1;
      mx2  <= mx1;
      zg2  <= zg1;
    end
  end

  // stage 3: gx*mg and mx*g2
  logic signed [tch_pkg::D_W-1:0]  gmg3, mgg3;
  logic signed [tch_pkg::S_W-1:0]  s3;
  logic        [tch_pkg::G2_W-1:0] g2_3;
  logic                            zg3, v3;

  always_ff @(posedge clk) begin
    if (en) begin
      gmg3 <= tch_pkg::D_W'(gx2) * tch_pkg::D_W'(mg2);
      mgg3 <= tch_pkg::D_W'(mx2) *
              $signed({{(tch_pkg::D_W - tch_pkg::G2_W){1'b0}}, g2_2});
      s3   <= s2;
      g2_3 <= g2_2;
      zg3  <= zg2;
    end
  end

  // stage 4: cosine numerator, square root operand
  tch_pkg::sqrt_t sq4;
  tch_pkg::side_t side4;
  logic           v4;

  always_ff @(posedge clk) begin
    if (en) begin
      sq4.rad     <= {g2_3[tch_pkg::RAD_W-2*tch_pkg::GFRAC-1:0], {(2*tch_pkg::GFRAC){1'b0}}};
      sq4.rem     <= '0;
      sq4.root    <= '0;
      side4.zero_g <= zg3;
      side4.s     <= s3;
      side4.d     <= gmg3 - mgg3;
    end
  end

  // valid flags of the front stages
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0; v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0;
    end else if (en) begin
      v0 <= sens.valid; v1 <= v0; v2 <= v1; v3 <= v2; v4 <= v3;
    end
  end

  // square root chain, one root bit per cell
  tch_pkg::sqrt_t sq_c   [SQ_N+1];
  tch_pkg::side_t side_c [SQ_N+1];
  logic           sq_v   [SQ_N+1];

  assign sq_c[0]   = sq4;
  assign side_c[0] = side4;
  assign sq_v[0]   = v4;

  for (genvar i = 0; i < SQ_N; i++) begin : g_sqrt
    tch_sqrt_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctl      (tch_pkg::ctl_t'{en: en, valid: sq_v[i]}),
      .sq_in    (sq_c[i]),
      .side_in  (side_c[i]),
      .sq_out   (sq_c[i+1]),
      .side_out (side_c[i+1]),
      .valid_out(sq_v[i+1])
    );
  end

  // stage 5: sine and cosine terms
  logic signed [tch_pkg::TERM_W-1:0] sine5, cos5;
  logic                              zg5, v5;

  always_ff @(posedge clk) begin
    if (en) begin
      sine5 <= $signed({{(tch_pkg::TERM_W - SQ_N){1'b0}}, sq_c[SQ_N].root}) *
               tch_pkg::TERM_W'(side_c[SQ_N].s);
      cos5  <= tch_pkg::TERM_W'(side_c[SQ_N].d) <<< tch_pkg::GFRAC;
      zg5   <= side_c[SQ_N].zero_g;
    end
  end

  // stage 6: half-plane rotation and joint normalisation
  logic signed [tch_pkg::TERM_W-1:0] xr, yr;
  logic        [tch_pkg::MAG_W-1:0]  ux, uy;
  logic signed [tch_pkg::TERM_W-1:0] yabs;
  logic                              ny;
  logic signed [tch_pkg::Z_W-1:0]    z0;
  tch_pkg::cord_t                    c6_next;

  always_comb begin
    if (cos5[tch_pkg::TERM_W-1]) begin
      xr = -cos5;
      yr = -sine5;
      z0 = sine5[tch_pkg::TERM_W-1] ? -tch_pkg::Z180 : tch_pkg::Z180;
    end else begin
      xr = cos5;
      yr = sine5;
      z0 = '0;
    end
    ny   = yr[tch_pkg::TERM_W-1];
    yabs = ny ? -yr : yr;
    ux   = xr[tch_pkg::MAG_W-1:0];
    uy   = yabs[tch_pkg::MAG_W-1:0];
    // greedy shifts of 16, 8, 4, 2, 1 until both fit below 2^29
    for (int k = 4; k >= 0; k--) begin
      if (((ux | uy) >> (tch_pkg::NORM_BITS - 1 + (1 << k))) != '0) begin
        ux = ux >> (1 << k);
        uy = uy >> (1 << k);
      end
    end
    c6_next.zero_g = zg5;
    c6_next.x      = $signed({1'b0, ux[tch_pkg::XY_W-2:0]});
    c6_next.y      = ny ? -$signed({1'b0, uy[tch_pkg::XY_W-2:0]})
                        :  $signed({1'b0, uy[tch_pkg::XY_W-2:0]});
    c6_next.z      = z0;
  end

  tch_pkg::cord_t c6;
  logic           v6;
  tch_pkg::cord_t c_c [CORDIC_STEPS+1];
  logic           c_v [CORDIC_STEPS+1];

  always_ff @(posedge clk) begin
    if (en) begin
      c6 <= c6_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else if (en) begin
      v5 <= sq_v[SQ_N];
      v6 <= v5;
    end
  end

  assign c_c[0] = c6;
  assign c_v[0] = v6;

  // rotation chain
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    tch_cordic_cell #(.STEP(i)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctl      (tch_pkg::ctl_t'{en: en, valid: c_v[i]}),
      .c_in     (c_c[i]),
      .c_out    (c_c[i+1]),
      .valid_out(c_v[i+1])
    );
  end

  // stage 7: angle to whole degrees
  logic signed [tch_pkg::HQ_W-1:0] hq;
  tch_pkg::res_t                   r7;
  logic                            v7;

  always_comb begin
    hq = tch_pkg::HQ_W'(c_c[CORDIC_STEPS].z) + tch_pkg::HQ180;
    if (hq[tch_pkg::HQ_W-1]) begin
      hq = hq + tch_pkg::HQ360;
    end
    if (hq >= tch_pkg::HQ360) begin
      hq = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r7.heading_deg <= c_c[CORDIC_STEPS].zero_g ? 9'd0 : hq[24:16];
      r7.no_gravity  <= c_c[CORDIC_STEPS].zero_g;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
    end else if (en) begin
      v7 <= c_v[CORDIC_STEPS];
    end
  end

  // output buffer
  tch_out_buf u_out_buf (
    .clk      (clk),
    .rst      (rst),
    .push     (v7 && en),
    .push_data(r7),
    .full     (full),
    .res      (res)
  );

  // checks
  a_no_grav_zero: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.no_gravity |-> res.heading_deg == 9'd0)
    else $error("no gravity beat with nonzero heading");

  a_range: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> res.heading_deg < 9'd360)
    else $error("heading out of range");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    full |=> $stable(v7) && $stable(r7))
    else $error("last stage moved while buffer full");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !res.valid)
    else $error("result beat right after reset");

  a_ready_en: assert property (@(posedge clk) disable iff (rst)
    sens.ready == !full)
    else $error("input ready does not follow buffer space");

endmodule

`default_nettype wire

FILE: sv/tch_sqrt_cell.sv
// ----------------------------------------------------------------------------
// tch_sqrt_cell: one digit of the floor square root
// Takes two operand bits, settles one root bit and hands on the side data.
// ----------------------------------------------------------------------------
`default_nettype none

module tch_sqrt_cell (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire tch_pkg::ctl_t ctl,
  input  wire tch_pkg::sqrt_t sq_in,
  input  wire tch_pkg::side_t side_in,
  output tch_pkg::sqrt_t     sq_out,
  output tch_pkg::side_t     side_out,
  output logic               valid_out
);

  logic [tch_pkg::REM_W-1:0] rem_sh;
  logic [tch_pkg::REM_W-1:0] trial;
  tch_pkg::sqrt_t            sq_next;

  // trial subtraction of (root*4 + 1)
  always_comb begin
    rem_sh  = {sq_in.rem[tch_pkg::REM_W-3:0], sq_in.rad[tch_pkg::RAD_W-1 -: 2]};
    trial   = {sq_in.root, 2'b01};
    sq_next.rad = {sq_in.rad[tch_pkg::RAD_W-3:0], 2'b00};
    if (rem_sh >= trial) begin
      sq_next.rem  = rem_sh - trial;
      sq_next.root = {sq_in.root[tch_pkg::ROOT_W-2:0], 1'b1};
    end else begin
      sq_next.rem  = rem_sh;
      sq_next.root = {sq_in.root[tch_pkg::ROOT_W-2:0], 1'b0};
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (ctl.en) begin
      sq_out   <= sq_next;
      side_out <= side_in;
    end
  end

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (ctl.en) begin
      valid_out <= ctl.valid;
    end
  end

endmodule

`default_nettype wire

FILE: sv/tch_cordic_cell.sv
// ----------------------------------------------------------------------------
// tch_cordic_cell: one vectoring step of the arctangent
// Rotates towards the x axis by atan(2^-STEP) and accumulates the angle.
// ----------------------------------------------------------------------------
`default_nettype none

module tch_cordic_cell #(
  parameter int STEP = 0
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire tch_pkg::ctl_t  ctl,
  input  wire tch_pkg::cord_t c_in,
  output tch_pkg::cord_t      c_out,
  output logic                valid_out
);

  logic signed [tch_pkg::XY_W-1:0] xs;
  logic signed [tch_pkg::XY_W-1:0] ys;
  logic signed [tch_pkg::Z_W-1:0]  ang;
  tch_pkg::cord_t                  c_next;

  // rotate unless y is already zero
  always_comb begin
    xs  = c_in.x >>> STEP;
    ys  = c_in.y >>> STEP;
    ang = $signed({{(tch_pkg::Z_W - tch_pkg::ATAN_W){1'b0}}, tch_pkg::ATAN_Q16[STEP]});
    c_next = c_in;
    if (!c_in.y[tch_pkg::XY_W-1] && c_in.y != '0) begin
      c_next.x = c_in.x + ys;
      c_next.y = c_in.y - xs;
      c_next.z = c_in.z + ang;
    end else if (c_in.y[tch_pkg::XY_W-1]) begin
      c_next.x = c_in.x - ys;
      c_next.y = c_in.y + xs;
      c_next.z = c_in.z - ang;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      c_out <= c_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (ctl.en) begin
      valid_out <= ctl.valid;
    end
  end

endmodule

`default_nettype wire

FILE: sv/tch_out_buf.sv
// ----------------------------------------------------------------------------
// tch_out_buf: two-entry output buffer
// Parts the pipeline from the receiver; full stalls the pipeline so
// that no result beat is dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module tch_out_buf (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire tch_pkg::res_t push_data,
  output logic               full,
  tch_out_if.source          res
);

  tch_pkg::res_t e0;
  tch_pkg::res_t e1;
  logic [1:0]    cnt;
  logic          pop;

  assign pop             = res.valid && res.ready;
  assign full            = (cnt == 2'd2);
  assign res.valid       = (cnt != 2'd0);
  assign res.heading_deg = e0.heading_deg;
  assign res.no_gravity  = e0.no_gravity;

  // fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end

  // entry storage, head in e0
  always_ff @(posedge clk) begin
    if (pop) begin
      if (cnt == 2'd2) begin
        e0 <= e1;
      end else if (push) begin
        e0 <= push_data;
      end
    end else if (push) begin
      if (cnt == 2'd0) begin
        e0 <= push_data;
      end else begin
        e1 <= push_data;
      end
    end
  end

endmodule

`default_nettype wire

FILE: tb/tb_tilt_compensated_heading.sv
// ----------------------------------------------------------------------------
// tb_tilt_compensated_heading: self-checking bench for the heading block
// Drives gravity/magnetic vector pairs with random gaps, predicts each
// heading with a local fixed-point model and checks every result beat in
// order, including a long output stall that fills the pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_tilt_compensated_heading;

  localparam int STEPS   = tch_pkg::CORDIC_STEPS_DEF;
  localparam int LATENCY = STEPS + 32;
  localparam longint LIMIT_CYCLES = 400000;

  typedef struct packed {
    logic [8:0] heading;
    logic       no_grav;
  } heading_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  tch_in_if  sens ();
  tch_out_if res ();

  tilt_compensated_heading i_dut (
    .clk  (clk),
    .rst  (rst),
    .sens (sens),
    .res  (res)
  );

  heading_t heading_q[$];
  int       n_errors = 0;
  longint   cycle_cnt = 0;
  bit       hold_off = 1'b0;

  // clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("tb_tilt_compensated_heading: done, errors");
      $finish;
    end
  end

  // floor square root of a 64-bit value
  function automatic longint unsigned root64(longint unsigned v);
    longint unsigned acc, bitv;
    acc = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= acc + bitv) begin
        v = v - (acc + bitv);
        acc = (acc >> 1) + bitv;
      end else begin
        acc = acc >> 1;
      end
      bitv = bitv >> 2;
    end
    return acc;
  endfunction

  // vectoring rotation giving the angle in Q16 degrees
  function automatic longint angle_q16(longint y, longint x);
    longint z, xs, ys;
    longint unsigned ux, uy;
    bit nx, ny;
    z = 0;
    if (x < 0) begin
      z = (y >= 0) ? 180 * 65536 : -180 * 65536;
      x = -x;
      y = -y;
    end
    nx = x < 0;
    ny = y < 0;
    ux = nx ? -x : x;
    uy = ny ? -y : y;
    while (ux >= (64'd1 << 29) || uy >= (64'd1 << 29)) begin
      ux = ux >> 1;
      uy = uy >> 1;
    end
    x = nx ? -longint'(ux) : longint'(ux);
    y = ny ? -longint'(uy) : longint'(uy);
    for (int i = 0; i < STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x = x + ys;
        y = y - xs;
        z = z + longint'(tch_pkg::ATAN_Q16[i]);
      end else if (y < 0) begin
        x = x - ys;
        y = y + xs;
        z = z - longint'(tch_pkg::ATAN_Q16[i]);
      end
    end
    return z;
  endfunction

  function automatic heading_t predict_heading(logic signed [15:0] gx16, gy16, gz16,
                                               mx16, my16, mz16);
    longint gx, gy, gz, mx, my, mz, s, g2, mg, d, sine, cosine, hq;
    heading_t r;
    gx = gx16; gy = gy16; gz = gz16;
    mx = mx16; my = my16; mz = mz16;
    r = '0;
    if (gx == 0 && gy == 0 && gz == 0) begin
      r.no_grav = 1'b1;
      return r;
    end
    s = gy * mz - gz * my;
    g2 = gx * gx + gy * gy + gz * gz;
    mg = mx * gx + my * gy + mz * gz;
    d = gx * mg - mx * g2;
    sine = longint'(root64(longint'(g2) << 16)) * s;
    cosine = d * 256;
    hq = angle_q16(sine, cosine) + 180 * 65536;
    if (hq < 0) hq = hq + 360 * 65536;
    if (hq >= 360 * 65536) hq = 0;
    r.heading = 9'(hq >>> 16);
    return r;
  endfunction

  // sender: one beat after a random or given gap, valid stays up when there is no gap
  task automatic send_vectors(logic signed [15:0] gx, gy, gz, mx, my, mz, int gap = -1);
    int wait_n;
    wait_n = (gap < 0) ? $urandom_range(0, 16) : gap;
    if (wait_n > 0) begin
      sens.valid <= 1'b0;
      repeat (wait_n) @(negedge clk);
    end
    sens.valid <= 1'b1;
    sens.grav_x <= gx; sens.grav_y <= gy; sens.grav_z <= gz;
    sens.mag_x <= mx;  sens.mag_y <= my;  sens.mag_z <= mz;
    do @(posedge clk); while (!sens.ready);
    heading_q.push_back(predict_heading(gx, gy, gz, mx, my, mz));
    @(negedge clk);
  endtask

  function automatic logic [15:0] rnd_sample();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'(int'($urandom_range(0, 8)) - 4);
      3: return 16'(int'($urandom_range(0, 2000)) - 1000);
      default: return 16'($urandom);
    endcase
  endfunction

  // receiver: random stalls, long hold-off on request
  initial begin
    int stall;
    res.ready = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_off) begin
        res.ready <= 1'b0;
        repeat (200) @(negedge clk);
        hold_off = 1'b0;
      end
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
      if (stall != 0) begin
        res.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      res.ready <= 1'b1;
      @(negedge clk);
    end
  end

  // result checker
  always @(posedge clk) begin
    heading_t got, want;
    if (!rst && res.valid && res.ready) begin
      got.heading = res.heading_deg;
      got.no_grav = res.no_gravity;
      if (heading_q.size() == 0) begin
        $display("%0t: unexpected beat heading %0d no_gravity %0b", $time,
                 got.heading, got.no_grav);
        n_errors++;
      end else begin
        want = heading_q.pop_front();
        if (got.heading !== want.heading) begin
          $display("%0t: heading_deg expected %0d actual %0d", $time,
                   want.heading, got.heading);
          n_errors++;
        end
        if (got.no_grav !== want.no_grav) begin
          $display("%0t: no_gravity expected %0b actual %0b", $time,
                   want.no_grav, got.no_grav);
          n_errors++;
        end
      end
    end
  end

  // edge values, zero gravity and degenerate projections
  task automatic test_directed();
    send_vectors(0, 0, 0, 100, 200, 300);
    send_vectors(0, 0, 0, 0, 0, 0);
    send_vectors(0, 0, 1000, 500, 0, 0);
    send_vectors(0, 0, 1000, 0, 500, 0);
    send_vectors(0, 0, 1000, -500, 0, 0);
    send_vectors(0, 0, 1000, 0, -500, 0);
    send_vectors(0, 0, 1000, 0, 0, 700);
    send_vectors(100, 200, 300, 200, 400, 600);
    send_vectors(1000, 0, 0, 10, 20, 30);
    send_vectors(-32768, -32768, -32768, -32768, -32768, -32768);
    send_vectors(32767, 32767, 32767, 32767, 32767, 32767);
    send_vectors(-32768, 32767, -32768, 32767, -32768, 32767);
    send_vectors(32767, -32768, 32767, -32768, 32767, -32768);
    send_vectors(0, 0, 1, 0, 0, 0);
    send_vectors(0, 0, -1, -1, 1, 0);
    send_vectors(1, 1, 1, -32768, 32767, 0);
    send_vectors(0, 0, 16384, -1000, -1, 0);
    send_vectors(0, 0, 16384, -1000, 1, 0);
  endtask

  // random vector pairs, mostly near-level gravity
  task automatic test_random(int n);
    logic signed [15:0] gx, gy, gz;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 3) != 0) begin
        gx = 16'(int'($urandom_range(0, 4000)) - 2000);
        gy = 16'(int'($urandom_range(0, 4000)) - 2000);
        gz = 16'(int'($urandom_range(8000, 16000)));
        send_vectors(gx, gy, gz, 16'($urandom), 16'($urandom), 16'($urandom));
      end else begin
        send_vectors(rnd_sample(), rnd_sample(), rnd_sample(),
                     rnd_sample(), rnd_sample(), rnd_sample());
      end
    end
  endtask

  // back-to-back beats while the receiver holds off
  task automatic test_backpressure();
    hold_off = 1'b1;
    for (int i = 0; i < 150; i++)
      send_vectors(16'($urandom), 16'($urandom), 16'($urandom | 1),
                   16'($urandom), 16'($urandom), 16'($urandom), 0);
  endtask

  initial begin
    sens.valid = 1'b0;
    sens.grav_x = '0; sens.grav_y = '0; sens.grav_z = '0;
    sens.mag_x = '0;  sens.mag_y = '0;  sens.mag_z = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_backpressure();
    test_random(1830);
    sens.valid <= 1'b0;
    while (heading_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (n_errors == 0) begin
      $display("tb_tilt_compensated_heading: done, clean");
    end else begin
      $display("tb_tilt_compensated_heading: done, errors");
    end
    $finish;
  end
endmodule

`default_nettype wire
